// File: rtl/fpf_pkg.sv
`default_nettype none

package fpf_pkg;

    localparam int PAYLOAD_BYTES_DEF = 16;
    localparam int BYTE_W            = 8;
    localparam int IDX_W             = 8;

    localparam logic [BYTE_W-1:0] SYNC_0 = 8'h44;
    localparam logic [BYTE_W-1:0] SYNC_1 = 8'h49;
    localparam logic [BYTE_W-1:0] SYNC_2 = 8'h59;
    localparam logic [BYTE_W-1:0] SYNC_3 = 8'h64;

    typedef enum logic [3:0] {
        PH_NEW,
        PH_SYNC0,
        PH_SYNC1,
        PH_SYNC2,
        PH_SYNC3,
        PH_LEN,
        PH_ID,
        PH_DATA,
        PH_SUMA,
        PH_SUMB
    } phase_t;

    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] data;
        logic              first;
        logic              last;
        logic [BYTE_W-1:0] pkt_id;
    } item_t;

    typedef struct packed {
        logic emit;
        logic take;
        logic frame_end;
    } emit_st_t;

endpackage

`default_nettype wire

// File: rtl/fletcher8_packet_framer_unit.sv
// Path: a payload byte is registered in the input register (fpf_in_reg), then in the output register.
// Throughput: one output byte per cycle from a single output register unless no item is
// held or result_ready stalls; sync, length and id lead a frame's first item, sums its last.
// Reset: rst_n is asynchronous, active low; clears packet_id, byte index, sums, phase
// and valid flags; no clearing pass.
`default_nettype none

module fletcher8_packet_framer_unit
    import fpf_pkg::*;
#(
    parameter int PAYLOAD_BYTES = PAYLOAD_BYTES_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              payload_valid,
    output logic                   payload_ready,
    input  wire logic [BYTE_W-1:0] payload_byte,
    input  wire logic              packet_id_we,
    input  wire logic [BYTE_W-1:0] packet_id_wdata,
    output logic                   result_valid,
    input  wire logic              result_ready,
    output logic [BYTE_W-1:0]      out_byte,
    output logic                   run_last,
    output logic                   frame_last
);

    logic [BYTE_W-1:0] packet_id_reg;
    logic [BYTE_W-1:0] packet_id_next;
    item_t             item;
    emit_st_t          st;

    assign packet_id_next = packet_id_we ? packet_id_wdata : packet_id_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            packet_id_reg <= '0;
        end
        else
        begin
            packet_id_reg <= packet_id_next;
        end
    end

    fpf_in_reg #(
        .PAYLOAD_BYTES (PAYLOAD_BYTES)
    ) u_in_reg (
        .clk           (clk),
        .rst_n         (rst_n),
        .payload_valid (payload_valid),
        .payload_ready (payload_ready),
        .payload_byte  (payload_byte),
        .packet_id     (packet_id_reg),
        .take          (st.take),
        .item          (item)
    );

    fpf_emit #(
        .PAYLOAD_BYTES (PAYLOAD_BYTES)
    ) u_emit (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .st           (st),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .out_byte     (out_byte),
        .run_last     (run_last),
        .frame_last   (frame_last)
    );

`ifndef ASSERT_OFF
    a_frame_end_run_end: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && frame_last) |-> run_last)
        else $error("frame end without item end");

    a_take_needs_emit: assert property (@(posedge clk) disable iff (!rst_n)
        st.take |-> st.emit)
        else $error("item released without emitting");

    a_frame_end_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        st.frame_end |-> (item.valid && item.last))
        else $error("checksum emitted for non-final item");

    a_emit_shows_valid: assert property (@(posedge clk) disable iff (!rst_n)
        st.emit |=> result_valid)
        else $error("emitted byte not presented");
`endif

endmodule

`default_nettype wire

// File: rtl/fpf_in_reg.sv
`default_nettype none

module fpf_in_reg
    import fpf_pkg::*;
#(
    parameter int PAYLOAD_BYTES = PAYLOAD_BYTES_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              payload_valid,
    output logic                   payload_ready,
    input  wire logic [BYTE_W-1:0] payload_byte,
    input  wire logic [BYTE_W-1:0] packet_id,
    input  wire logic              take,
    output item_t                  item
);

    item_t             item_reg;
    item_t             item_next;
    logic [IDX_W-1:0]  byte_index_reg;
    logic [IDX_W-1:0]  byte_index_next;
    logic              accept;
    logic              is_last;

    assign payload_ready = !item_reg.valid || take;
    assign accept        = payload_valid && payload_ready;
    assign is_last       = (byte_index_reg == IDX_W'(PAYLOAD_BYTES - 1));

    always_comb
    begin
        item_next       = item_reg;
        byte_index_next = byte_index_reg;
        if (take)
        begin
            item_next.valid = 1'b0;
        end
        if (accept)
        begin
            item_next.valid  = 1'b1;
            item_next.data   = payload_byte;
            item_next.first  = (byte_index_reg == '0);
            item_next.last   = is_last;
            item_next.pkt_id = packet_id;
            byte_index_next  = is_last ? '0 : byte_index_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_reg       <= '0;
            byte_index_reg <= '0;
        end
        else
        begin
            item_reg       <= item_next;
            byte_index_reg <= byte_index_next;
        end
    end

    assign item = item_reg;

endmodule

`default_nettype wire

// File: rtl/fpf_emit.sv
`default_nettype none

module fpf_emit
    import fpf_pkg::*;
#(
    parameter int PAYLOAD_BYTES = PAYLOAD_BYTES_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire item_t             item,
    output emit_st_t               st,
    output logic                   result_valid,
    input  wire logic              result_ready,
    output logic [BYTE_W-1:0]      out_byte,
    output logic                   run_last,
    output logic                   frame_last
);

    localparam logic [BYTE_W-1:0] LEN_BYTE = BYTE_W'(PAYLOAD_BYTES);

    phase_t            phase_reg;
    phase_t            phase_next;
    phase_t            cur;
    phase_t            succ;
    logic [BYTE_W-1:0] sum_a_reg;
    logic [BYTE_W-1:0] sum_a_next;
    logic [BYTE_W-1:0] sum_b_reg;
    logic [BYTE_W-1:0] sum_b_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [BYTE_W-1:0] out_byte_reg;
    logic [BYTE_W-1:0] out_byte_next;
    logic              run_last_reg;
    logic              run_last_next;
    logic              frame_last_reg;
    logic              frame_last_next;
    logic              emit;
    logic              done;
    logic [BYTE_W-1:0] add_val;

    always_comb
    begin
        cur = phase_reg;
        if (phase_reg == PH_NEW)
        begin
            cur = item.first ? PH_SYNC0 : PH_DATA;
        end
    end

    assign emit = item.valid && (!out_valid_reg || result_ready);
    assign done = ((cur == PH_DATA) && !item.last) || (cur == PH_SUMB);

    // next state
    always_comb
    begin
        case (cur)
            PH_SYNC0: succ = PH_SYNC1;
            PH_SYNC1: succ = PH_SYNC2;
            PH_SYNC2: succ = PH_SYNC3;
            PH_SYNC3: succ = PH_LEN;
            PH_LEN:   succ = PH_ID;
            PH_ID:    succ = PH_DATA;
            PH_DATA:  succ = item.last ? PH_SUMA : PH_NEW;
            PH_SUMA:  succ = PH_SUMB;
            default:  succ = PH_NEW;
        endcase
        phase_next = emit ? succ : phase_reg;
    end

    // outputs and sums
    always_comb
    begin
        out_valid_next  = out_valid_reg && !result_ready;
        out_byte_next   = out_byte_reg;
        run_last_next   = run_last_reg;
        frame_last_next = frame_last_reg;
        sum_a_next      = sum_a_reg;
        sum_b_next      = sum_b_reg;
        add_val         = item.data;
        case (cur)
            PH_SYNC0: out_byte_next = SYNC_0;
            PH_SYNC1: out_byte_next = SYNC_1;
            PH_SYNC2: out_byte_next = SYNC_2;
            PH_SYNC3: out_byte_next = SYNC_3;
            PH_LEN:   out_byte_next = LEN_BYTE;
            PH_ID:
            begin
                out_byte_next = item.pkt_id;
                add_val       = item.pkt_id;
            end
            PH_DATA:  out_byte_next = item.data;
            PH_SUMA:  out_byte_next = sum_a_reg;
            PH_SUMB:  out_byte_next = sum_b_reg;
            default:  out_byte_next = item.data;
        endcase
        if (emit)
        begin
            out_valid_next  = 1'b1;
            run_last_next   = done;
            frame_last_next = (cur == PH_SUMB);
            if (cur == PH_LEN)
            begin
                sum_a_next = LEN_BYTE;
                sum_b_next = LEN_BYTE;
            end
            else if ((cur == PH_ID) || (cur == PH_DATA))
            begin
                sum_a_next = sum_a_reg + add_val;
                sum_b_next = sum_b_reg + sum_a_reg + add_val;
            end
        end
        else
        begin
            out_byte_next = out_byte_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_NEW;
            out_valid_reg <= 1'b0;
            sum_a_reg     <= '0;
            sum_b_reg     <= '0;
        end
        else
        begin
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
            sum_a_reg     <= sum_a_next;
            sum_b_reg     <= sum_b_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_byte_reg   <= out_byte_next;
        run_last_reg   <= run_last_next;
        frame_last_reg <= frame_last_next;
    end

    assign st.emit      = emit;
    assign st.take      = emit && done;
    assign st.frame_end = emit && (cur == PH_SUMB);

    assign result_valid = out_valid_reg;
    assign out_byte     = out_byte_reg;
    assign run_last     = run_last_reg;
    assign frame_last   = frame_last_reg;

endmodule

`default_nettype wire

// File: tb/fletcher8_packet_framer_unit_tb.sv
`timescale 1ns / 1ps

module fletcher8_packet_framer_unit_tb
    import fpf_pkg::*;
();

    localparam int PAYLOAD_BYTES  = PAYLOAD_BYTES_DEF;
    localparam int HOLD_CYCLES    = 120;
    localparam int SETTLE_CYCLES  = 4;
    localparam int WATCHDOG_LIMIT = 1000;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              run_end;
        logic              frame_end;
    } framed_byte_t;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              payload_valid;
    logic              payload_ready;
    logic [BYTE_W-1:0] payload_byte;
    logic              packet_id_we;
    logic [BYTE_W-1:0] packet_id_wdata;
    logic              result_valid;
    logic              result_ready;
    logic [BYTE_W-1:0] out_byte;
    logic              run_last;
    logic              frame_last;

    framed_byte_t      framed_bytes_q[$];
    logic [IDX_W-1:0]  frame_index;
    logic [BYTE_W-1:0] fletcher_a;
    logic [BYTE_W-1:0] fletcher_b;
    logic [BYTE_W-1:0] current_id;

    int                mismatch_count;
    int                quiet_cycles;
    bit                tx_idle;
    bit                rx_idle;
    bit                hold_request;

    fletcher8_packet_framer_unit #(
        .PAYLOAD_BYTES(PAYLOAD_BYTES)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .payload_valid(payload_valid),
        .payload_ready(payload_ready),
        .payload_byte(payload_byte),
        .packet_id_we(packet_id_we),
        .packet_id_wdata(packet_id_wdata),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .out_byte(out_byte),
        .run_last(run_last),
        .frame_last(frame_last)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic void add_to_sums(input logic [BYTE_W-1:0] b);
        fletcher_a = fletcher_a + b;
        fletcher_b = fletcher_b + fletcher_a;
    endfunction

    function automatic void push_framed(input logic [BYTE_W-1:0] b, input logic ends_frame);
        framed_byte_t fb;
        fb.data      = b;
        fb.run_end   = 1'b0;
        fb.frame_end = ends_frame;
        framed_bytes_q = {framed_bytes_q, fb};
    endfunction

    function automatic void frame_payload_byte(input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] len;
        len = BYTE_W'(PAYLOAD_BYTES);
        if (frame_index == '0)
        begin
            push_framed(SYNC_0, 1'b0);
            push_framed(SYNC_1, 1'b0);
            push_framed(SYNC_2, 1'b0);
            push_framed(SYNC_3, 1'b0);
            fletcher_a = '0;
            fletcher_b = '0;
            push_framed(len, 1'b0);
            add_to_sums(len);
            push_framed(current_id, 1'b0);
            add_to_sums(current_id);
        end
        push_framed(b, 1'b0);
        add_to_sums(b);
        frame_index = frame_index + 1'b1;
        if (frame_index >= PAYLOAD_BYTES)
        begin
            push_framed(fletcher_a, 1'b0);
            push_framed(fletcher_b, 1'b1);
            frame_index = '0;
        end
        framed_bytes_q[framed_bytes_q.size() - 1].run_end = 1'b1;
    endfunction

    function automatic logic [BYTE_W-1:0] random_byte();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return BYTE_W'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_payload(input logic [BYTE_W-1:0] b);
        int gap;
        gap = tx_idle ? $urandom_range(0, 3) : 0;
        if (gap > 0)
        begin
            payload_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        payload_valid <= 1'b1;
        payload_byte  <= b;
        do
            @(posedge clk);
        while (!payload_ready);
        frame_payload_byte(b);
    endtask

    task automatic wait_drained();
        payload_valid <= 1'b0;
        while (framed_bytes_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_packet_id(input logic [BYTE_W-1:0] id);
        wait_drained();
        packet_id_we    <= 1'b1;
        packet_id_wdata <= id;
        @(posedge clk);
        current_id = id;
        packet_id_we <= 1'b0;
    endtask

    task automatic check_result();
        framed_byte_t exp;
        if (framed_bytes_q.size() == 0)
        begin
            $display("%0t: unexpected item out_byte %02h run_last %0b frame_last %0b",
                     $time, out_byte, run_last, frame_last);
            mismatch_count++;
            return;
        end
        exp = framed_bytes_q.pop_front();
        if (out_byte !== exp.data)
        begin
            $display("%0t: out_byte expected %02h actual %02h", $time, exp.data, out_byte);
            mismatch_count++;
        end
        if (run_last !== exp.run_end)
        begin
            $display("%0t: run_last expected %0b actual %0b", $time, exp.run_end, run_last);
            mismatch_count++;
        end
        if (frame_last !== exp.frame_end)
        begin
            $display("%0t: frame_last expected %0b actual %0b",
                     $time, exp.frame_end, frame_last);
            mismatch_count++;
        end
    endtask

    task automatic test_first_frame();
        logic [BYTE_W-1:0] pattern[16] = '{8'h00, 8'hFF, 8'h01, 8'h02, 8'h04, 8'h08,
                                           8'h10, 8'h20, 8'h40, 8'h80, 8'hFE, 8'hFD,
                                           8'hFB, 8'hF7, 8'hEF, 8'hDF};
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        foreach (pattern[i])
            send_payload(pattern[i]);
    endtask

    task automatic test_id_change_mid_frame();
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        repeat (4) send_payload(8'hFF);
        set_packet_id(8'hFF);
        repeat (4) send_payload(8'hFF);
    endtask

    task automatic test_random_traffic();
        logic [BYTE_W-1:0] ids[6];
        ids = '{8'h00, 8'h80, 8'h5A, BYTE_W'($urandom_range(0, 255)), 8'hFF,
                BYTE_W'($urandom_range(0, 255))};
        for (int p = 0; p < 6; p++)
        begin
            set_packet_id(ids[p]);
            tx_idle = (p % 3) != 0;
            rx_idle = (p % 2) != 0;
            repeat ($urandom_range(28, 48)) send_payload(random_byte());
        end
    endtask

    task automatic test_output_backpressure();
        tx_idle      = 1'b0;
        rx_idle      = 1'b1;
        hold_request = 1'b1;
        repeat (48) send_payload(random_byte());
    endtask

    task automatic test_sender_pause();
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        repeat (20) send_payload(random_byte());
        wait_drained();
        repeat (20) send_payload(random_byte());
    endtask

    // hold ready low on request, otherwise, when rx_idle is set, stall at random before each item
    initial
    begin
        int stall;
        result_ready <= 1'b0;
        do
            @(posedge clk);
        while (!rst_n);
        forever
        begin
            if (hold_request)
            begin
                result_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_request = 1'b0;
            end
            else
            begin
                stall = rx_idle ? $urandom_range(0, 3) : 0;
                if (stall > 0)
                begin
                    result_ready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
                result_ready <= 1'b1;
                do
                    @(posedge clk);
                while (!result_valid && !hold_request);
                if (result_valid)
                    check_result();
            end
        end
    end

    always @(posedge clk)
    begin
        if ((payload_valid && payload_ready) || (result_valid && result_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        rst_n           <= 1'b0;
        payload_valid   <= 1'b0;
        payload_byte    <= '0;
        packet_id_we    <= 1'b0;
        packet_id_wdata <= '0;
        mismatch_count  = 0;
        quiet_cycles    = 0;
        tx_idle         = 1'b0;
        rx_idle         = 1'b0;
        hold_request    = 1'b0;
        frame_index     = '0;
        fletcher_a      = '0;
        fletcher_b      = '0;
        current_id      = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_first_frame();
        test_id_change_mid_frame();
        test_random_traffic();
        test_output_backpressure();
        test_sender_pause();

        wait_drained();
        repeat (10) @(posedge clk);
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
